// ----- hdl/u8c_pkg.sv -----
// shared types and constants for the utf-8 console decoder
`timescale 1ns / 1ps
`default_nettype none

package u8c_pkg;

  localparam logic [7:0]  BELL_BYTE  = 8'h07;
  localparam logic [7:0]  TAB_BYTE   = 8'h09;
  localparam logic [20:0] SPACE_CHAR = 21'h20;
  localparam logic [15:0] LF_UNIT    = 16'h000A;
  localparam logic [15:0] CR_UNIT    = 16'h000D;
  localparam logic [20:0] LF_CHAR    = 21'h00000A;
  localparam logic [7:0]  LEAD2_MIN  = 8'hC0;
  localparam logic [7:0]  LEAD3_MIN  = 8'hE0;
  localparam logic [7:0]  LEAD4_MIN  = 8'hF0;
  localparam logic [7:0]  LEAD_MAX   = 8'hF7;
  localparam logic [1:0]  HUSH_LINES = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       end_of_message;
    logic       to_error_channel;
  } item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        out_channel;
    logic        decode_error;
    logic        last_of_run;
  } result_t;

  // results from one request, up to two
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

`default_nettype wire

// ----- hdl/u8c_if.sv -----
// valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps
`default_nettype none

interface u8c_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic       end_of_message;
  logic       to_error_channel;

  modport source (output valid, cmd, data_byte, end_of_message, to_error_channel,
                  input ready);
  modport sink (input valid, cmd, data_byte, end_of_message, to_error_channel,
                output ready);
endinterface

interface u8c_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        out_channel;
  logic        decode_error;
  logic        last_of_run;

  modport source (output valid, code_unit, out_channel, decode_error, last_of_run,
                  input ready);
  modport sink (input valid, code_unit, out_channel, decode_error, last_of_run,
                output ready);
endinterface

`default_nettype wire

// ----- hdl/u8c_step.sv -----
// decoder state and the per-byte decode logic
`timescale 1ns / 1ps
`default_nettype none

module u8c_step (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire u8c_pkg::item_t       item,
  output u8c_pkg::result_pair_t     res
);
  import u8c_pkg::*;

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [20:0] partial_code, partial_code_next;
  logic [1:0]  hush_count, hush_count_next;
  logic        error_latched, error_latched_next;

  logic        do_emit;
  logic        do_err;
  logic [20:0] emit_ch;
  logic [7:0]  b;
  logic        eom;
  logic        chan;
  logic [20:0] shifted;

  assign b       = item.data_byte;
  assign eom     = item.end_of_message;
  assign chan    = item.to_error_channel;
  assign shifted = {partial_code[14:0], b[5:0]};

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_code_next  = partial_code;
    hush_count_next    = hush_count;
    error_latched_next = error_latched;
    do_emit            = 1'b0;
    do_err             = 1'b0;
    emit_ch            = '0;
    res                = '0;

    if (item.cmd) begin
      hush_count_next = HUSH_LINES;
    end else if (error_latched) begin
      if (eom) error_latched_next = 1'b0;
    end else if (bytes_pending == 2'd0) begin
      if (!b[7]) begin
        if (b != BELL_BYTE) begin
          do_emit = 1'b1;
          emit_ch = (b == TAB_BYTE) ? SPACE_CHAR : {13'd0, b};
        end
      end else if (b < LEAD2_MIN || b > LEAD_MAX) begin
        do_err = 1'b1;
      end else begin
        if (b < LEAD3_MIN) begin
          partial_code_next  = {16'd0, b[4:0]};
          bytes_pending_next = 2'd1;
        end else if (b < LEAD4_MIN) begin
          partial_code_next  = {17'd0, b[3:0]};
          bytes_pending_next = 2'd2;
        end else begin
          partial_code_next  = {18'd0, b[2:0]};
          bytes_pending_next = 2'd3;
        end
        // lead byte at end of message is an error, as the sequence cannot complete
        if (eom) do_err = 1'b1;
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        do_err = 1'b1;
      end else begin
        bytes_pending_next = bytes_pending - 2'd1;
        if (bytes_pending == 2'd1) begin
          partial_code_next = '0;
          do_emit           = 1'b1;
          emit_ch           = shifted;
        end else begin
          partial_code_next = shifted;
          if (eom) do_err = 1'b1;
        end
      end
    end

    if (do_err) begin
      bytes_pending_next     = '0;
      partial_code_next      = '0;
      error_latched_next     = ~eom;
      res.count              = 2'd1;
      res.first.out_channel  = chan;
      res.first.decode_error = 1'b1;
      res.first.last_of_run  = 1'b1;
    end else if (do_emit) begin
      if (hush_count != 2'd0) begin
        // hushed: full code point compare for the line count
        if (emit_ch == LF_CHAR) hush_count_next = hush_count - 2'd1;
      end else if (emit_ch[15:0] == LF_UNIT) begin
        res.count              = 2'd2;
        res.first.code_unit    = LF_UNIT;
        res.first.out_channel  = chan;
        res.second.code_unit   = CR_UNIT;
        res.second.out_channel = chan;
        res.second.last_of_run = 1'b1;
      end else begin
        res.count             = 2'd1;
        res.first.code_unit   = emit_ch[15:0];
        res.first.out_channel = chan;
        res.first.last_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      partial_code  <= '0;
      hush_count    <= '0;
      error_latched <= 1'b0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      partial_code  <= partial_code_next;
      hush_count    <= hush_count_next;
      error_latched <= error_latched_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/u8c_out_buf.sv -----
// two-slot result register that drains one result per cycle while the receiver is ready
`timescale 1ns / 1ps
`default_nettype none

module u8c_out_buf (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire u8c_pkg::result_pair_t res,
  input  wire logic                  pop,
  output logic                       can_load,
  output logic                       has_result,
  output u8c_pkg::result_t           head
);
  import u8c_pkg::*;

  logic [1:0] count;
  result_t    slot0;
  result_t    slot1;

  assign has_result = (count != 2'd0);
  assign head       = slot0;
  // space for a new request once at most one result is left and it goes now
  assign can_load   = (count == 2'd0) || (count == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= res.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= res.first;
      slot1 <= res.second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/utf8_to_utf16_console_decoder.sv -----
// top level: utf-8 byte stream to 16-bit console code units
// latency: a result is shown the cycle after its request is taken
// throughput: one byte per cycle unless paused; a line feed also queues a trailing CR
// the request side pauses while two results are queued, or one is held and not taken
// reset (rst, synchronous): clears decode state, hush count, error latch and results
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_console_decoder (
  input wire logic clk,
  input wire logic rst,
  u8c_in_if.sink   in_item,
  u8c_out_if.source out_res
);
  import u8c_pkg::*;

  item_t        item;
  result_pair_t res;
  result_t      head;
  logic         accept;
  logic         can_load;
  logic         has_result;
  logic         pop;

  assign item = {in_item.cmd, in_item.data_byte, in_item.end_of_message,
                 in_item.to_error_channel};

  assign pop           = has_result && out_res.ready;
  assign in_item.ready = can_load;
  assign accept        = in_item.valid && can_load;

  u8c_step step (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .res    (res)
  );

  u8c_out_buf obuf (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .res        (res),
    .pop        (pop),
    .can_load   (can_load),
    .has_result (has_result),
    .head       (head)
  );

  assign out_res.valid        = has_result;
  assign out_res.code_unit    = head.code_unit;
  assign out_res.out_channel  = head.out_channel;
  assign out_res.decode_error = head.decode_error;
  assign out_res.last_of_run  = head.last_of_run;

endmodule

`default_nettype wire

// ----- hdl/u8c_checker.sv -----
// port checks for the decoder and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

module u8c_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] code_unit,
  input wire logic        out_channel,
  input wire logic        decode_error,
  input wire logic        last_of_run
);
  import u8c_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_unit) &&
      $stable(out_channel) && $stable(decode_error) && $stable(last_of_run))
    else $error("result changed while stalled");

  // error results are single and carry a zero code unit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && decode_error |-> code_unit == '0 && last_of_run)
    else $error("malformed error result");

  // a line feed that does not end its run is followed at once by CR on the same channel
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !decode_error && !last_of_run
    |=> out_valid && code_unit == CR_UNIT && last_of_run && !decode_error &&
        out_channel == $past(out_channel))
    else $error("missing CR after line feed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !decode_error && !last_of_run |-> code_unit == LF_UNIT)
    else $error("only a line feed opens a two-result run");

  // request side stalls only behind pending results
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("request stalled with no result pending");

endmodule

bind utf8_to_utf16_console_decoder u8c_checker chk (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_item.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .code_unit    (out_res.code_unit),
  .out_channel  (out_res.out_channel),
  .decode_error (out_res.decode_error),
  .last_of_run  (out_res.last_of_run)
);

`default_nettype wire

// ----- sim/tb.sv -----
// testbench for the utf-8 console decoder: directed table, then random messages
`timescale 1ns / 1ps

module tb;
  import u8c_pkg::*;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_HUSH  = 1'b1;
  localparam logic CH_NORMAL = 1'b0;
  localparam logic CH_ERROR  = 1'b1;
  localparam int   PREDICT   = -1;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   ITEMS_PER_PHASE = 250;

  typedef struct {
    item_t   req;
    int      n;
    result_t e0;
    result_t e1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  u8c_in_if  in_ch ();
  u8c_out_if out_ch ();

  utf8_to_utf16_console_decoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_ch),
    .out_res (out_ch)
  );

  always #4 clk = ~clk;

  // decoder state as the predictor sees it
  logic [1:0]  dec_left = 2'd0;
  logic [20:0] dec_bits = 21'd0;
  logic [1:0]  hush_left = 2'd0;
  logic        drop_rest = 1'b0;

  result_t   units_q[$];
  result_t   predicted[$];
  stim_row_t rows[$];
  item_t     msg_q[$];

  int        row_n;
  result_t   row_e0, row_e1;
  int        sender_idle_pct;
  int        recv_stall_pct;
  int        errors = 0;
  int        quiet_cycles = 0;

  function automatic result_t unit_res(logic [15:0] u, logic ch, logic err, logic last);
    result_t r;
    r.code_unit    = u;
    r.out_channel  = ch;
    r.decode_error = err;
    r.last_of_run  = last;
    return r;
  endfunction

  function automatic void put_char(logic [20:0] ch, logic chan);
    logic [15:0] unit;
    unit = ch[15:0];
    if (hush_left != 2'd0) begin
      // hush counts full code points, not truncated units
      if (ch == LF_CHAR) hush_left = hush_left - 2'd1;
      return;
    end
    if (unit == LF_UNIT) begin
      predicted.push_back(unit_res(unit, chan, 1'b0, 1'b0));
      predicted.push_back(unit_res(CR_UNIT, chan, 1'b0, 1'b1));
    end else begin
      predicted.push_back(unit_res(unit, chan, 1'b0, 1'b1));
    end
  endfunction

  function automatic void flag_bad(logic chan, logic eom);
    dec_left  = 2'd0;
    dec_bits  = 21'd0;
    drop_rest = !eom;
    predicted.push_back(unit_res(16'h0000, chan, 1'b1, 1'b1));
  endfunction

  function automatic void decode_byte(item_t it);
    logic [7:0]  b;
    logic [20:0] ch;
    b = it.data_byte;
    if (it.cmd == CMD_HUSH) begin
      hush_left = HUSH_LINES;
      return;
    end
    if (drop_rest) begin
      if (it.end_of_message) drop_rest = 1'b0;
      return;
    end
    if (dec_left == 2'd0) begin
      if (b < 8'h80) begin
        if (b == BELL_BYTE) return;
        put_char((b == TAB_BYTE) ? SPACE_CHAR : {13'd0, b}, it.to_error_channel);
        return;
      end
      if (b < LEAD2_MIN || b > LEAD_MAX) begin
        flag_bad(it.to_error_channel, it.end_of_message);
        return;
      end
      if (b < LEAD3_MIN) begin
        dec_bits = {16'd0, b[4:0]};
        dec_left = 2'd1;
      end else if (b < LEAD4_MIN) begin
        dec_bits = {17'd0, b[3:0]};
        dec_left = 2'd2;
      end else begin
        dec_bits = {18'd0, b[2:0]};
        dec_left = 2'd3;
      end
      if (it.end_of_message) flag_bad(it.to_error_channel, it.end_of_message);
      return;
    end
    if (b[7:6] != 2'b10) begin
      flag_bad(it.to_error_channel, it.end_of_message);
      return;
    end
    dec_bits = {dec_bits[14:0], b[5:0]};
    dec_left = dec_left - 2'd1;
    if (dec_left == 2'd0) begin
      ch = dec_bits;
      dec_bits = 21'd0;
      put_char(ch, it.to_error_channel);
      return;
    end
    if (it.end_of_message) flag_bad(it.to_error_channel, it.end_of_message);
  endfunction

  task automatic add_row(logic cmd, logic [7:0] b, logic eom, logic ch, int n,
                         result_t e0 = '0, result_t e1 = '0);
    stim_row_t r;
    r.req.cmd              = cmd;
    r.req.data_byte        = b;
    r.req.end_of_message   = eom;
    r.req.to_error_channel = ch;
    r.n  = n;
    r.e0 = e0;
    r.e1 = e1;
    rows.push_back(r);
  endtask

  task automatic build_directed();
    add_row(CMD_DATA, 8'h41, 1'b1, CH_NORMAL, 1, unit_res(16'h0041, CH_NORMAL, 1'b0, 1'b1));
    add_row(CMD_DATA, 8'h00, 1'b0, CH_ERROR, 1, unit_res(16'h0000, CH_ERROR, 1'b0, 1'b1));
    add_row(CMD_DATA, 8'h7F, 1'b0, CH_NORMAL, 1, unit_res(16'h007F, CH_NORMAL, 1'b0, 1'b1));
    add_row(CMD_DATA, BELL_BYTE, 1'b0, CH_NORMAL, 0);
    add_row(CMD_DATA, TAB_BYTE, 1'b0, CH_ERROR, 1, unit_res(16'h0020, CH_ERROR, 1'b0, 1'b1));
    add_row(CMD_DATA, 8'h0A, 1'b1, CH_NORMAL, 2, unit_res(LF_UNIT, CH_NORMAL, 1'b0, 1'b0),
            unit_res(CR_UNIT, CH_NORMAL, 1'b0, 1'b1));
    // bad lead bytes, one ending the message and one latching the drop
    add_row(CMD_DATA, 8'h80, 1'b1, CH_ERROR, 1, unit_res(16'h0000, CH_ERROR, 1'b1, 1'b1));
    add_row(CMD_DATA, 8'hFF, 1'b0, CH_NORMAL, 1, unit_res(16'h0000, CH_NORMAL, 1'b1, 1'b1));
    add_row(CMD_DATA, 8'h41, 1'b1, CH_NORMAL, 0);
    // multi-byte forms, channel switching mid-sequence
    add_row(CMD_DATA, 8'hC2, 1'b0, CH_NORMAL, PREDICT);
    add_row(CMD_DATA, 8'hA9, 1'b0, CH_ERROR, PREDICT);
    add_row(CMD_DATA, 8'hE2, 1'b0, CH_NORMAL, PREDICT);
    add_row(CMD_DATA, 8'h82, 1'b0, CH_ERROR, PREDICT);
    add_row(CMD_DATA, 8'hAC, 1'b0, CH_NORMAL, PREDICT);
    // largest lead, value truncates to a line feed
    add_row(CMD_DATA, LEAD_MAX, 1'b0, CH_NORMAL, PREDICT);
    add_row(CMD_DATA, 8'h80, 1'b0, CH_NORMAL, PREDICT);
    add_row(CMD_DATA, 8'h80, 1'b0, CH_NORMAL, PREDICT);
    add_row(CMD_DATA, 8'h8A, 1'b1, CH_NORMAL, PREDICT);
    // message ends mid-sequence
    add_row(CMD_DATA, 8'hC3, 1'b1, CH_ERROR, 1, unit_res(16'h0000, CH_ERROR, 1'b1, 1'b1));
    // bad continuation, then hush arrives while the rest is dropped
    add_row(CMD_DATA, LEAD3_MIN, 1'b0, CH_NORMAL, PREDICT);
    add_row(CMD_DATA, 8'h41, 1'b0, CH_NORMAL, 1, unit_res(16'h0000, CH_NORMAL, 1'b1, 1'b1));
    add_row(CMD_HUSH, 8'hFF, 1'b1, CH_ERROR, 0);
    add_row(CMD_DATA, 8'h0A, 1'b1, CH_NORMAL, 0);
    add_row(CMD_DATA, 8'h0A, 1'b0, CH_NORMAL, 0);
    // errors still come out while hushed
    add_row(CMD_DATA, 8'hBF, 1'b1, CH_ERROR, 1, unit_res(16'h0000, CH_ERROR, 1'b1, 1'b1));
    add_row(CMD_DATA, 8'h0A, 1'b0, CH_NORMAL, 0);
    add_row(CMD_DATA, 8'h42, 1'b1, CH_NORMAL, 1, unit_res(16'h0042, CH_NORMAL, 1'b0, 1'b1));
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // mostly well-formed messages, some corrupted, some pure noise
  task automatic build_message();
    logic [7:0] bytes[$];
    int kind, pos;
    item_t it;
    msg_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 8)) bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            case ($urandom_range(0, 7))
              0: bytes.push_back(BELL_BYTE);
              1: bytes.push_back(TAB_BYTE);
              2, 3: bytes.push_back(8'h0A);
              default: bytes.push_back(8'($urandom_range(0, 127)));
            endcase
          end
          4, 5: begin
            bytes.push_back(LEAD2_MIN | 8'($urandom_range(0, 31)));
            bytes.push_back(cont_byte());
          end
          6, 7: begin
            bytes.push_back(LEAD3_MIN | 8'($urandom_range(0, 15)));
            repeat (2) bytes.push_back(cont_byte());
          end
          default: begin
            bytes.push_back(LEAD4_MIN | 8'($urandom_range(0, 7)));
            repeat (3) bytes.push_back(cont_byte());
          end
        endcase
      end
      if (kind < 25) begin
        pos = $urandom_range(0, bytes.size() - 1);
        case ($urandom_range(0, 2))
          0: bytes[pos] = $urandom_range(0, 1) ? cont_byte() : 8'hF8 | 8'($urandom_range(0, 7));
          1: while (bytes.size() > pos + 1) void'(bytes.pop_back());
          default: bytes[pos] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    foreach (bytes[i]) begin
      if ($urandom_range(0, 29) == 0) begin
        it.cmd              = CMD_HUSH;
        it.data_byte        = 8'($urandom_range(0, 255));
        it.end_of_message   = 1'($urandom_range(0, 1));
        it.to_error_channel = 1'($urandom_range(0, 1));
        msg_q.push_back(it);
      end
      it.cmd              = CMD_DATA;
      it.data_byte        = bytes[i];
      it.end_of_message   = (i == bytes.size() - 1) || (kind < 10 && $urandom_range(0, 3) == 0);
      it.to_error_channel = 1'($urandom_range(0, 1));
      msg_q.push_back(it);
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_req(item_t it, int n, result_t e0, result_t e1);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.cmd              <= it.cmd;
    in_ch.data_byte        <= it.data_byte;
    in_ch.end_of_message   <= it.end_of_message;
    in_ch.to_error_channel <= it.to_error_channel;
    row_n  = n;
    row_e0 = e0;
    row_e1 = e1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result check first, then prediction for the request taken on this edge
  always @(posedge clk) begin
    result_t want;
    item_t   req;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (units_q.size() == 0) begin
          $error("unexpected result: code_unit %h, out_channel %b, decode_error %b",
                 out_ch.code_unit, out_ch.out_channel, out_ch.decode_error);
          errors++;
        end else begin
          want = units_q.pop_front();
          if (out_ch.code_unit !== want.code_unit) begin
            $error("code_unit: expected %h, got %h", want.code_unit, out_ch.code_unit);
            errors++;
          end
          if (out_ch.out_channel !== want.out_channel) begin
            $error("out_channel: expected %b, got %b", want.out_channel, out_ch.out_channel);
            errors++;
          end
          if (out_ch.decode_error !== want.decode_error) begin
            $error("decode_error: expected %b, got %b", want.decode_error,
                   out_ch.decode_error);
            errors++;
          end
          if (out_ch.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, out_ch.last_of_run);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        req.cmd              = in_ch.cmd;
        req.data_byte        = in_ch.data_byte;
        req.end_of_message   = in_ch.end_of_message;
        req.to_error_channel = in_ch.to_error_channel;
        predicted.delete();
        decode_byte(req);
        if (row_n == PREDICT) begin
          foreach (predicted[i]) units_q.push_back(predicted[i]);
        end else begin
          if (row_n > 0) units_q.push_back(row_e0);
          if (row_n > 1) units_q.push_back(row_e1);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int idle_tbl[4];
    int stall_tbl[4];
    int sent;
    idle_tbl  = '{0, 87, 0, 14};
    stall_tbl = '{0, 0, 87, 14};
    in_ch.valid            = 1'b0;
    in_ch.cmd              = CMD_DATA;
    in_ch.data_byte        = 8'h00;
    in_ch.end_of_message   = 1'b0;
    in_ch.to_error_channel = CH_NORMAL;
    row_n           = PREDICT;
    row_e0          = '0;
    row_e1          = '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    build_directed();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) drive_req(rows[i].req, rows[i].n, rows[i].e0, rows[i].e1);
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_tbl[ph];
      recv_stall_pct  = stall_tbl[ph];
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        build_message();
        foreach (msg_q[i]) begin
          drive_req(msg_q[i], PREDICT, '0, '0);
          if (msg_q[i].cmd == CMD_DATA) sent++;
        end
      end
    end
    in_ch.valid <= 1'b0;
    recv_stall_pct = 0;
    while (units_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
